// ===== rtl/bed_pkg.sv =====
// shared types, widths and utf-8 helpers for the backslash escape decoder
package bed_pkg;

    localparam int BYTE_W      = 8;
    localparam int VAL_W       = 32;
    localparam int LEN_W       = 3;
    localparam int POS_W       = 3;
    localparam int TOTAL_W     = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_INDEX_W = 1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_ENABLE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NO_NEWLINE    = 1'd1;

    // pending code: len 0 means nothing, len 1 with a raw byte is a plain byte
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [VAL_W-1:0] val;
    } pend_t;

    // one work packet from the front end: pending code, one byte, then space/newline
    typedef struct packed {
        pend_t             pend;
        logic              b1_valid;
        logic [BYTE_W-1:0] b1;
        logic              tail_valid;
        logic [BYTE_W-1:0] tail;
    } job_t;

    function automatic logic [VAL_W-1:0] utf8_clip(input logic [VAL_W-1:0] v);
        utf8_clip = v[VAL_W-1] ? 32'h7FFF_FFFF : v;
    endfunction

    function automatic logic [LEN_W-1:0] utf8_len(input logic [VAL_W-1:0] v);
        if (v < 32'h80)
            utf8_len = 3'd1;
        else if (v < 32'h800)
            utf8_len = 3'd2;
        else if (v < 32'h1_0000)
            utf8_len = 3'd3;
        else if (v < 32'h20_0000)
            utf8_len = 3'd4;
        else if (v < 32'h400_0000)
            utf8_len = 3'd5;
        else
            utf8_len = 3'd6;
    endfunction

    function automatic logic [BYTE_W-1:0] utf8_lead(input logic [LEN_W-1:0] n);
        case (n)
            3'd2:    utf8_lead = 8'hC0;
            3'd3:    utf8_lead = 8'hE0;
            3'd4:    utf8_lead = 8'hF0;
            3'd5:    utf8_lead = 8'hF8;
            3'd6:    utf8_lead = 8'hFC;
            default: utf8_lead = 8'h00;
        endcase
    endfunction

    // byte k of the n-byte encoding of v
    function automatic logic [BYTE_W-1:0] utf8_byte(
        input logic [VAL_W-1:0] v,
        input logic [LEN_W-1:0] n,
        input logic [POS_W-1:0] k
    );
        logic [LEN_W-1:0] sh;
        logic [VAL_W-1:0] s;
        sh = n - 3'd1 - k;
        case (sh)
            3'd1:    s = v >> 6;
            3'd2:    s = v >> 12;
            3'd3:    s = v >> 18;
            3'd4:    s = v >> 24;
            3'd5:    s = v >> 30;
            default: s = v;
        endcase
        if (k == '0)
            utf8_byte = utf8_lead(n) | s[BYTE_W-1:0];
        else
            utf8_byte = {2'b10, s[5:0]};
    endfunction

endpackage

// ===== rtl/bed_front.sv =====
// front end: parses escapes per transaction and builds one work packet
module bed_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_fire,
    input  logic [7:0]    data_byte,
    input  logic          has_byte,
    input  logic          end_of_word,
    input  logic          end_of_line,
    input  logic          escape_enable,
    input  logic          no_newline,
    output logic          push,
    output bed_pkg::job_t job
);
    import bed_pkg::*;

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_BSLASH,
        MODE_OCTAL,
        MODE_HEX,
        MODE_UNI
    } mode_t;

    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_A       = 8'h61;
    localparam logic [7:0] CH_B       = 8'h62;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_E_LO    = 8'h65;
    localparam logic [7:0] CH_E_UP    = 8'h45;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_N       = 8'h6E;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_T       = 8'h74;
    localparam logic [7:0] CH_V       = 8'h76;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_U_LO    = 8'h75;
    localparam logic [7:0] CH_U_UP    = 8'h55;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CODE_BEL   = 8'h07;
    localparam logic [7:0] CODE_BS    = 8'h08;
    localparam logic [7:0] CODE_ESC   = 8'h1B;
    localparam logic [7:0] CODE_FF    = 8'h0C;
    localparam logic [7:0] CODE_CR    = 8'h0D;
    localparam logic [7:0] CODE_TAB   = 8'h09;
    localparam logic [7:0] CODE_VT    = 8'h0B;

    mode_t       mode_reg, mode_next;
    logic [3:0]  digits_reg, digits_next;
    logic [31:0] acc_reg, acc_next;
    logic        silenced_reg, silenced_next;

    logic        dig_valid;
    logic [3:0]  dig_val;
    logic        dig_ok;
    logic [31:0] acc_shift;
    logic        set_mute;
    pend_t       fin_eow;

    // {valid, value} of a hex digit character
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            hex_digit = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66)
            hex_digit = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46)
            hex_digit = {1'b1, 4'(c - 8'h37)};
        else
            hex_digit = 5'd0;
    endfunction

    // what a pending escape emits when it is closed
    function automatic pend_t finish(input mode_t m, input logic [31:0] a);
        pend_t p;
        p = '0;
        case (m)
            MODE_BSLASH:
            begin
                p.len = 3'd1;
                p.val = {24'd0, CH_BSLASH};
            end
            MODE_OCTAL, MODE_HEX:
            begin
                p.len = 3'd1;
                p.val = {24'd0, a[7:0]};
            end
            MODE_UNI:
            begin
                p.val = utf8_clip(a);
                p.len = utf8_len(p.val);
            end
            default: p = '0;
        endcase
        finish = p;
    endfunction

    assign {dig_valid, dig_val} = hex_digit(data_byte);

    always_comb
    begin
        case (mode_reg)
            MODE_OCTAL: acc_shift = {24'd0, acc_reg[4:0], dig_val[2:0]};
            MODE_HEX:   acc_shift = {24'd0, acc_reg[3:0], dig_val};
            default:    acc_shift = {acc_reg[27:0], dig_val};
        endcase
    end

    assign dig_ok = dig_valid && (digits_reg != 4'd0)
                    && !((mode_reg == MODE_OCTAL) && dig_val[3]);

    always_comb
    begin
        mode_next     = mode_reg;
        digits_next   = digits_reg;
        acc_next      = acc_reg;
        job           = '0;
        set_mute      = 1'b0;
        fin_eow       = '0;

        if (has_byte)
        begin
            if (escape_enable)
            begin
                if ((mode_reg == MODE_OCTAL) || (mode_reg == MODE_HEX) || (mode_reg == MODE_UNI))
                begin
                    if (dig_ok)
                    begin
                        if (digits_reg == 4'd1)
                        begin
                            job.pend    = finish(mode_reg, acc_shift);
                            mode_next   = MODE_NORMAL;
                            digits_next = 4'd0;
                            acc_next    = 32'd0;
                        end
                        else
                        begin
                            digits_next = digits_reg - 4'd1;
                            acc_next    = acc_shift;
                        end
                    end
                    else
                    begin
                        // digit run ends here, byte handled as text below
                        job.pend    = finish(mode_reg, acc_reg);
                        mode_next   = MODE_NORMAL;
                        digits_next = 4'd0;
                        acc_next    = 32'd0;
                    end
                end

                if (!(dig_ok && ((mode_reg == MODE_OCTAL) || (mode_reg == MODE_HEX)
                                 || (mode_reg == MODE_UNI))))
                begin
                    if (mode_next == MODE_BSLASH)
                    begin
                        mode_next    = MODE_NORMAL;
                        job.b1_valid = 1'b1;
                        unique case (data_byte) inside
                            CH_A:             job.b1 = CODE_BEL;
                            CH_B:             job.b1 = CODE_BS;
                            CH_E_LO, CH_E_UP: job.b1 = CODE_ESC;
                            CH_F:             job.b1 = CODE_FF;
                            CH_N:             job.b1 = CH_NEWLINE;
                            CH_R:             job.b1 = CODE_CR;
                            CH_T:             job.b1 = CODE_TAB;
                            CH_V:             job.b1 = CODE_VT;
                            CH_BSLASH:        job.b1 = CH_BSLASH;
                            CH_C:
                            begin
                                job.b1_valid = 1'b0;
                                set_mute     = 1'b1;
                            end
                            CH_ZERO:
                            begin
                                job.b1_valid = 1'b0;
                                mode_next    = MODE_OCTAL;
                                digits_next  = 4'd3;
                                acc_next     = 32'd0;
                            end
                            CH_X:
                            begin
                                job.b1_valid = 1'b0;
                                mode_next    = MODE_HEX;
                                digits_next  = 4'd2;
                                acc_next     = 32'd0;
                            end
                            CH_U_LO:
                            begin
                                job.b1_valid = 1'b0;
                                mode_next    = MODE_UNI;
                                digits_next  = 4'd4;
                                acc_next     = 32'd0;
                            end
                            CH_U_UP:
                            begin
                                job.b1_valid = 1'b0;
                                mode_next    = MODE_UNI;
                                digits_next  = 4'd8;
                                acc_next     = 32'd0;
                            end
                            default:          job.b1 = data_byte;
                        endcase
                    end
                    else if (data_byte == CH_BSLASH)
                    begin
                        mode_next = MODE_BSLASH;
                    end
                    else
                    begin
                        mode_next    = MODE_NORMAL;
                        job.b1_valid = 1'b1;
                        job.b1       = data_byte;
                    end
                end
            end
            else
            begin
                // escapes off: close anything pending, pass byte through
                job.pend     = finish(mode_reg, acc_reg);
                mode_next    = MODE_NORMAL;
                digits_next  = 4'd0;
                acc_next     = 32'd0;
                job.b1_valid = 1'b1;
                job.b1       = data_byte;
            end
        end

        if (end_of_word || end_of_line)
        begin
            fin_eow = finish(mode_next, acc_next);
            // only a lone backslash can be left open after an earlier close
            if (fin_eow.len != '0)
            begin
                if (job.pend.len == '0)
                begin
                    job.pend = fin_eow;
                end
                else
                begin
                    job.b1_valid = 1'b1;
                    job.b1       = fin_eow.val[7:0];
                end
            end
            mode_next   = MODE_NORMAL;
            digits_next = 4'd0;
            acc_next    = 32'd0;
            if (end_of_line)
            begin
                job.tail_valid = !no_newline;
                job.tail       = CH_NEWLINE;
            end
            else
            begin
                job.tail_valid = 1'b1;
                job.tail       = CH_SPACE;
            end
        end

        silenced_next = end_of_line ? 1'b0 : (silenced_reg | set_mute);
    end

    assign push = in_fire && !(silenced_reg || set_mute)
                  && ((job.pend.len != '0) || job.b1_valid || job.tail_valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_NORMAL;
            digits_reg   <= 4'd0;
            acc_reg      <= 32'd0;
            silenced_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            mode_reg     <= mode_next;
            digits_reg   <= digits_next;
            acc_reg      <= acc_next;
            silenced_reg <= silenced_next;
        end
    end

    // digit modes always have digits left, other modes none
    a_digits_match_mode: assert property (@(posedge clk) disable iff (!rst_n)
        ((mode_reg == MODE_OCTAL) || (mode_reg == MODE_HEX) || (mode_reg == MODE_UNI))
        == (digits_reg != 4'd0))
        else $error("digit count out of step with parse mode");

endmodule

// ===== rtl/bed_queue.sv =====
// small register queue of work packets between front and back end
module bed_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bed_pkg::job_t push_job,
    output logic          not_full,
    input  logic          pop,
    output logic          head_valid,
    output bed_pkg::job_t head_job
);
    import bed_pkg::*;

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign not_full   = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

// ===== rtl/bed_back.sv =====
// back end: expands a work packet into output bytes, one per cycle unless out_ready stalls
module bed_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  bed_pkg::job_t q_job,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [7:0]    out_byte,
    output logic          last_of_run
);
    import bed_pkg::*;

    job_t               cur_job_reg;
    logic               cur_valid_reg;
    logic [POS_W-1:0]   pos_reg;
    logic               out_valid_reg;
    logic [BYTE_W-1:0]  out_byte_reg;
    logic               out_last_reg;

    logic [TOTAL_W-1:0] cur_total;
    logic               cur_last;
    logic [BYTE_W-1:0]  cur_byte;
    logic               advance;

    assign cur_total = TOTAL_W'(cur_job_reg.pend.len)
                       + TOTAL_W'(cur_job_reg.b1_valid)
                       + TOTAL_W'(cur_job_reg.tail_valid);
    assign cur_last  = ((TOTAL_W'(pos_reg) + 1'b1) == cur_total);

    // code bytes first, then the single byte, then space or newline
    always_comb
    begin
        if (pos_reg < cur_job_reg.pend.len)
            cur_byte = utf8_byte(cur_job_reg.pend.val, cur_job_reg.pend.len, pos_reg);
        else if (cur_job_reg.b1_valid && (pos_reg == cur_job_reg.pend.len))
            cur_byte = cur_job_reg.b1;
        else
            cur_byte = cur_job_reg.tail;
    end

    assign advance = cur_valid_reg && (!out_valid_reg || out_ready);
    assign q_pop   = q_valid && (!cur_valid_reg || (advance && cur_last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
                pos_reg       <= '0;
            end
            else if (advance)
            begin
                if (cur_last)
                    cur_valid_reg <= 1'b0;
                else
                    pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_job_reg <= q_job;
        if (advance)
        begin
            out_byte_reg <= cur_byte;
            out_last_reg <= cur_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = out_last_reg;

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (TOTAL_W'(pos_reg) < cur_total))
        else $error("byte position past end of packet");

endmodule

// ===== rtl/backslash_escape_decoder.sv =====
// top level of the backslash escape decoder: config registers, front, queue, back
// path: an input transaction goes into the packet queue, then the back end's packet register, then the output register
// throughput: one result byte per cycle while out_ready does not stall; an input transaction with k result
//   bytes holds the output serializer for all k bytes, a silent one costs none
// input is taken every cycle while the 2-entry packet queue has room
// reset: rst_n async active low clears parse state, config, queue and output
module backslash_escape_decoder (
    input  logic       clk,
    input  logic       rst_n,
    // input byte channel
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       has_byte,
    input  logic       end_of_word,
    input  logic       end_of_line,
    // output byte channel
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [bed_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic       cfg_data
);
    import bed_pkg::*;

    logic escape_enable_reg;
    logic no_newline_reg;
    logic in_fire;
    logic push;
    logic q_not_full;
    logic q_valid;
    logic q_pop;
    job_t front_job;
    job_t head_job;

    // config writes are registered and always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_enable_reg <= 1'b0;
            no_newline_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ESCAPE_ENABLE: escape_enable_reg <= cfg_data;
                CFG_NO_NEWLINE:    no_newline_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    // input transaction taken whenever the queue can absorb a packet
    assign in_ready = q_not_full;
    assign in_fire  = in_valid && in_ready;

    // front end classifies the byte and tracks escape state
    bed_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (in_fire),
        .data_byte    (data_byte),
        .has_byte     (has_byte),
        .end_of_word  (end_of_word),
        .end_of_line  (end_of_line),
        .escape_enable(escape_enable_reg),
        .no_newline   (no_newline_reg),
        .push         (push),
        .job          (front_job)
    );

    // decouples parsing from byte expansion
    bed_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (front_job),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .head_valid(q_valid),
        .head_job  (head_job)
    );

    // back end serializes utf-8 bytes, plain byte and separator
    bed_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_job      (head_job),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .last_of_run(last_of_run)
    );

endmodule

// ===== tb/bed_stream_checker.sv =====
// output checker for the backslash escape decoder: predicts bytes per input transaction
module bed_stream_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       has_byte,
    input  logic       end_of_word,
    input  logic       end_of_line,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic       last_of_run,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [bed_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic       cfg_data,
    output int         fail_count,
    output int         outstanding
);

    import bed_pkg::*;

    typedef enum logic [2:0] {
        PM_NORMAL,
        PM_BSLASH,
        PM_OCTAL,
        PM_HEX,
        PM_UNI
    } parse_mode_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } out_beat_t;

    localparam int         MAX_RUN   = 8;
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // mirrored configuration and parser state
    logic        esc_en;
    logic        no_nl;
    parse_mode_t mode;
    logic [3:0]  digits;
    logic [31:0] acc;
    logic        mute;

    logic [7:0] run_bytes[$];
    out_beat_t  expected_bytes[$];
    int         errors;

    function automatic void emit(input logic [7:0] b);
        if (!mute && run_bytes.size() < MAX_RUN)
            run_bytes.push_back(b);
    endfunction

    function automatic void emit_utf8(input logic [31:0] code);
        logic [31:0] v;
        logic [7:0]  enc[6];
        logic [7:0]  lead;
        int          n;
        int          k;
        v = code[31] ? 32'h7FFF_FFFF : code;
        if (v < 32'h80)
            n = 1;
        else if (v < 32'h800)
            n = 2;
        else if (v < 32'h1_0000)
            n = 3;
        else if (v < 32'h20_0000)
            n = 4;
        else if (v < 32'h400_0000)
            n = 5;
        else
            n = 6;
        for (k = n - 1; k > 0; k--)
        begin
            enc[k] = {2'b10, v[5:0]};
            v = v >> 6;
        end
        case (n)
            2:       lead = 8'hC0;
            3:       lead = 8'hE0;
            4:       lead = 8'hF0;
            5:       lead = 8'hF8;
            6:       lead = 8'hFC;
            default: lead = 8'h00;
        endcase
        enc[0] = lead | v[7:0];
        for (k = 0; k < n; k++)
            emit(enc[k]);
    endfunction

    function automatic int digit_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
            return int'(c - "0");
        if (c >= "a" && c <= "f")
            return int'(c - "a") + 10;
        if (c >= "A" && c <= "F")
            return int'(c - "A") + 10;
        return -1;
    endfunction

    function automatic void close_escape();
        case (mode)
            PM_BSLASH:       emit(CH_BSLASH);
            PM_OCTAL, PM_HEX: emit(acc[7:0]);
            PM_UNI:          emit_utf8(acc);
            default:         ;
        endcase
        mode   = PM_NORMAL;
        digits = '0;
        acc    = '0;
    endfunction

    function automatic void open_digits(input parse_mode_t m, input logic [3:0] count);
        mode   = m;
        digits = count;
        acc    = '0;
    endfunction

    function automatic void after_bslash(input logic [7:0] c);
        mode = PM_NORMAL;
        case (c)
            "a":      emit(CH_BEL);
            "b":      emit(CH_BS);
            "e", "E": emit(CH_ESC);
            "f":      emit(CH_FF);
            "n":      emit(CH_LF);
            "r":      emit(CH_CR);
            "t":      emit(CH_TAB);
            "v":      emit(CH_VT);
            "\\":     emit(CH_BSLASH);
            "c":      mute = 1'b1;
            "0":      open_digits(PM_OCTAL, 4'd3);
            "x":      open_digits(PM_HEX, 4'd2);
            "u":      open_digits(PM_UNI, 4'd4);
            "U":      open_digits(PM_UNI, 4'd8);
            default:  emit(c);
        endcase
    endfunction

    function automatic void escaped(input logic [7:0] c);
        int d;
        if (mode == PM_OCTAL || mode == PM_HEX || mode == PM_UNI)
        begin
            d = digit_of(c);
            if (mode == PM_OCTAL && d > 7)
                d = -1;
            if (d >= 0 && digits != 0)
            begin
                // octal and hex wrap to 8 bits, unicode keeps all 32
                if (mode == PM_OCTAL)
                    acc = {24'd0, 8'((acc << 3) + 32'(d))};
                else if (mode == PM_HEX)
                    acc = {24'd0, 8'((acc << 4) + 32'(d))};
                else
                    acc = (acc << 4) + 32'(d);
                digits = digits - 4'd1;
                if (digits == 0)
                    close_escape();
                return;
            end
            // not a digit: finish the escape, then treat the byte as text
            close_escape();
        end
        if (mode == PM_BSLASH)
            after_bslash(c);
        else if (c == CH_BSLASH)
            mode = PM_BSLASH;
        else
        begin
            mode = PM_NORMAL;
            emit(c);
        end
    endfunction

    function automatic void decode_item(input logic [7:0] c, input logic has,
                                        input logic eow, input logic eol);
        int k;
        run_bytes.delete();
        if (has)
        begin
            if (esc_en)
                escaped(c);
            else
            begin
                close_escape();
                emit(c);
            end
        end
        if (eow || eol)
        begin
            close_escape();
            if (eol)
            begin
                if (!no_nl)
                    emit(CH_LF);
                mute = 1'b0;
            end
            else
                emit(CH_SPACE);
        end
        for (k = 0; k < run_bytes.size(); k++)
            expected_bytes.push_back('{run_bytes[k], k == run_bytes.size() - 1});
    endfunction

    always @(posedge clk)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            esc_en = 1'b0;
            no_nl  = 1'b0;
            mode   = PM_NORMAL;
            digits = '0;
            acc    = '0;
            mute   = 1'b0;
            errors = 0;
            expected_bytes.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ESCAPE_ENABLE: esc_en = cfg_data;
                    CFG_NO_NEWLINE:    no_nl  = cfg_data;
                    default:           ;
                endcase
            end
            if (in_valid && in_ready)
                decode_item(data_byte, has_byte, end_of_word, end_of_line);
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $error("out_byte transaction with nothing expected: actual %02h", out_byte);
                    errors++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %02h actual %02h", want.out_byte, out_byte);
                        errors++;
                    end
                    if (last_of_run !== want.last)
                    begin
                        $error("last_of_run: expected %0b actual %0b", want.last, last_of_run);
                        errors++;
                    end
                end
            end
        end
        outstanding <= expected_bytes.size();
        fail_count  <= errors;
    end

endmodule

// ===== tb/tb_top.sv =====
// top of the backslash escape decoder bench: clock, reset, stimulus and verdict
module tb_top;

    import bed_pkg::*;

    localparam logic [7:0] BSLASH = 8'h5C;
    // idle margin kept after the last predicted byte has come out
    localparam int SETTLE_CYCLES = 8;

    logic       clk;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [7:0] data_byte   = 8'h00;
    logic       has_byte    = 1'b0;
    logic       end_of_word = 1'b0;
    logic       end_of_line = 1'b0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       cfg_valid   = 1'b0;
    logic       cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_ESCAPE_ENABLE;
    logic       cfg_data    = 1'b0;

    int fail_count;
    int outstanding;

    // percentage of cycles in which the sender holds back or the sink stalls
    int idle_pct  = 27;
    int stall_pct = 27;
    int items_sent = 0;

    logic [7:0] word_buf[$];

    backslash_escape_decoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .has_byte    (has_byte),
        .end_of_word (end_of_word),
        .end_of_line (end_of_line),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    bed_stream_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .has_byte    (has_byte),
        .end_of_word (end_of_word),
        .end_of_line (end_of_line),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sink side back-pressure, redrawn every cycle
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    // hard stop in case the decoder hangs
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // one input transaction; returns at the edge where it is taken
    task automatic put_item(input logic [7:0] c, input logic has,
                            input logic eow, input logic eol);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= c;
        has_byte    <= has;
        end_of_word <= eow;
        end_of_line <= eol;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items_sent++;
    endtask

    // wait until every predicted byte has come out and the pipe is quiet
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] hex_char();
        int d;
        d = $urandom_range(21);
        if (d < 10)
            return 8'(d) + "0";
        else if (d < 16)
            return 8'(d - 10) + "a";
        return 8'(d - 16) + "A";
    endfunction

    function automatic logic [7:0] simple_letter();
        case ($urandom_range(10))
            0:       return "a";
            1:       return "b";
            2:       return "e";
            3:       return "E";
            4:       return "f";
            5:       return "n";
            6:       return "r";
            7:       return "t";
            8:       return "v";
            9:       return BSLASH;
            default: return "c";
        endcase
    endfunction

    // append one piece of text to word_buf: mostly plain text and well-formed escapes
    function automatic void add_token();
        int         kind;
        int         n;
        int         k;
        logic [7:0] c;
        bit         fill_f;
        kind = $urandom_range(99);
        if (kind < 30)
        begin
            c = 8'($urandom_range(126, 32));
            word_buf.push_back(c == BSLASH ? 8'("z") : c);
        end
        else if (kind < 45)
        begin
            word_buf.push_back(BSLASH);
            word_buf.push_back(simple_letter());
        end
        else if (kind < 55)
        begin
            // any byte after a backslash, mostly unknown escapes
            word_buf.push_back(BSLASH);
            word_buf.push_back(8'($urandom_range(255)));
        end
        else if (kind < 65)
        begin
            word_buf.push_back(BSLASH);
            word_buf.push_back("0");
            n = $urandom_range(3);
            for (k = 0; k < n; k++)
                word_buf.push_back(8'($urandom_range(7)) + "0");
            if ($urandom_range(3) == 0)
                word_buf.push_back("8");
        end
        else if (kind < 93)
        begin
            word_buf.push_back(BSLASH);
            if (kind < 75)
            begin
                word_buf.push_back("x");
                n = $urandom_range(2);
            end
            else if (kind < 85)
            begin
                word_buf.push_back("u");
                n = $urandom_range(4);
            end
            else
            begin
                word_buf.push_back("U");
                n = $urandom_range(8);
            end
            // all-F digits give the largest value; eight of them after U drive the code point to the clip value
            fill_f = ($urandom_range(3) == 0);
            for (k = 0; k < n; k++)
                word_buf.push_back(fill_f ? 8'("F") : hex_char());
        end
        else if (kind < 97)
            word_buf.push_back(8'($urandom_range(255)));
        else
            word_buf.push_back(BSLASH);
    endfunction

    // send word_buf as one word, closing it with a word or line mark
    task automatic put_word(input bit eol);
        int k;
        bit eow;
        eow = eol ? bit'($urandom_range(1)) : 1'b1;
        if (word_buf.size() == 0)
            put_item(8'($urandom_range(255)), 1'b0, eow, eol);
        for (k = 0; k < word_buf.size(); k++)
        begin
            // occasional marker-only transaction that must produce nothing
            if ($urandom_range(24) == 0)
                put_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0);
            if (k == word_buf.size() - 1)
                put_item(word_buf[k], 1'b1, eow, eol);
            else
                put_item(word_buf[k], 1'b1, 1'b0, 1'b0);
        end
        word_buf.delete();
    endtask

    initial
    begin
        int n_words;
        int n_tok;
        int w;
        int t;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pass-through with both byte extremes
        write_reg(CFG_ESCAPE_ENABLE, 1'b0);
        write_reg(CFG_NO_NEWLINE, 1'b0);
        put_item(8'h00, 1'b1, 1'b0, 1'b0);
        put_item(8'hFF, 1'b1, 1'b1, 1'b0);
        put_item(BSLASH, 1'b1, 1'b0, 1'b1);
        settle();

        write_reg(CFG_ESCAPE_ENABLE, 1'b1);
        // hex escape cut short by the word end
        put_item(BSLASH, 1'b1, 1'b0, 1'b0);
        put_item("x", 1'b1, 1'b0, 1'b0);
        put_item("4", 1'b1, 1'b1, 1'b0);
        // octal escape ended by a non-octal digit, which then prints
        put_item(BSLASH, 1'b1, 1'b0, 1'b0);
        put_item("0", 1'b1, 1'b0, 1'b0);
        put_item("9", 1'b1, 1'b0, 1'b0);
        // unknown escape
        put_item(BSLASH, 1'b1, 1'b0, 1'b0);
        put_item("q", 1'b1, 1'b0, 1'b0);
        // trailing backslash stays literal
        put_item(BSLASH, 1'b1, 1'b1, 1'b0);
        // marker only, then an empty word and an empty line
        put_item(8'hA5, 1'b0, 1'b0, 1'b0);
        put_item(8'h5A, 1'b0, 1'b1, 1'b0);
        put_item(8'h00, 1'b0, 1'b0, 1'b1);
        // silencing eats text, space and newline up to the line end
        put_item(BSLASH, 1'b1, 1'b0, 1'b0);
        put_item("c", 1'b1, 1'b0, 1'b0);
        put_item("z", 1'b1, 1'b1, 1'b0);
        put_item("y", 1'b1, 1'b0, 1'b1);
        settle();

        // escapes switched off while a backslash is pending
        write_reg(CFG_NO_NEWLINE, 1'b1);
        put_item(BSLASH, 1'b1, 1'b0, 1'b0);
        settle();
        write_reg(CFG_ESCAPE_ENABLE, 1'b0);
        put_item("n", 1'b1, 1'b0, 1'b1);
        settle();

        write_reg(CFG_ESCAPE_ENABLE, 1'b1);
        write_reg(CFG_NO_NEWLINE, 1'b0);

        // random lines of words; a config change now and then between lines
        while (items_sent < 450)
        begin
            // one long stretch where neither side ever idles
            if (items_sent >= 170 && items_sent < 290)
            begin
                idle_pct  = 0;
                stall_pct = 0;
            end
            else
            begin
                idle_pct  = 27;
                stall_pct = 27;
                if ($urandom_range(5) == 0)
                begin
                    settle();
                    write_reg(CFG_ESCAPE_ENABLE, $urandom_range(3) != 0);
                    write_reg(CFG_NO_NEWLINE, 1'($urandom_range(1)));
                end
            end
            n_words = $urandom_range(4, 1);
            for (w = 0; w < n_words; w++)
            begin
                n_tok = $urandom_range(4);
                for (t = 0; t < n_tok; t++)
                    add_token();
                put_word(w == n_words - 1);
            end
        end

        settle();
        @(posedge clk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
